>>> rtl/core/chm_pkg.sv
// Shared types and constants for the chained hash map.
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_W       = 31;
    localparam int VALUE_OUT_W = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic {
        OP_FIND   = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Control part of the request token that walks the cell chain.
    typedef struct packed {
        logic  active;
        op_t   op;
        logic  hit;
        logic  placed;
    } tok_ctl_t;

    typedef struct packed {
        status_t                  status;
        logic [VALUE_OUT_W-1:0]   found_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic [COUNT_OUT_W-1:0]   bucket_count;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/chm_intf.sv
// Request and response channel interfaces of the chained hash map.
`timescale 1ns / 1ps
`default_nettype none
interface chm_req_if #(
    parameter int VALUE_BITS = chm_pkg::VALUE_BITS_DEF
);
    import chm_pkg::*;

    logic                  valid;
    logic                  ready;
    op_t                   op;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, op, key, value, input ready);
    modport sink   (input valid, op, key, value, output ready);
endinterface

interface chm_rsp_if;
    import chm_pkg::*;

    logic                   valid;
    logic                   ready;
    status_t                status;
    logic [VALUE_OUT_W-1:0] found_value;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [COUNT_OUT_W-1:0] bucket_count;

    modport source (output valid, status, found_value, entry_count, bucket_count,
                    input ready);
    modport sink   (input valid, status, found_value, entry_count, bucket_count,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/chained_hash_map.sv
// Top level of the chained hash map: cell chain, counters and response stage.
// One request in flight at a time: the token walks the full cell chain, one cell
//   per cycle, and the next request enters once it leaves and no response waits
//   in the pending register.
// Reset: all cells empty, entry count zero, bucket count one; no clearing pass,
//   the block takes a request in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_map #(
    parameter int CAPACITY   = chm_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = chm_pkg::VALUE_BITS_DEF
) (
    input  wire  clk,
    input  wire  rst_n,
    chm_req_if.sink   req,
    chm_rsp_if.source rsp
);
    import chm_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Bucket count stays at most 2*CAPACITY+1.
    localparam int BT_W  = $clog2(2 * CAPACITY + 2);

    // Token bus along the chain: index 0 feeds the first cell, index
    // CAPACITY is the output of the last one.
    tok_ctl_t              tok_ctl  [0:CAPACITY];
    logic [KEY_W-1:0]      tok_key  [0:CAPACITY];
    logic [VALUE_BITS-1:0] tok_data [0:CAPACITY];

    logic busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [BT_W-1:0]  bt_reg, bt_next;

    rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    rsp_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;

    logic accept;
    logic exit_tok;
    logic out_fire;
    rsp_t res;
    logic [CNT_W-1:0] cnt_new;
    logic [BT_W-1:0]  bt_new;

    // One request in flight at a time; a finished response may still sit in
    // the output register while the next request is taken.
    assign req.ready = !busy_reg && !pend_valid_reg;
    assign accept    = req.valid && req.ready;

    assign tok_ctl[0]  = '{active: accept, op: req.op, hit: 1'b0, placed: 1'b0};
    assign tok_key[0]  = req.key;
    assign tok_data[0] = req.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        chm_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (tok_ctl[i]),
            .key_in   (tok_key[i]),
            .data_in  (tok_data[i]),
            .ctl_out  (tok_ctl[i+1]),
            .key_out  (tok_key[i+1]),
            .data_out (tok_data[i+1])
        );
    end

    assign exit_tok = tok_ctl[CAPACITY].active;
    assign out_fire = out_valid_reg && rsp.ready;

    // Result of the token leaving the chain. A placed entry bumps the count;
    // growth to 2m+1 happens once the count reaches the bucket count.
    always_comb
    begin
        cnt_new = count_reg + CNT_W'(tok_ctl[CAPACITY].placed);
        bt_new  = bt_reg;
        if (tok_ctl[CAPACITY].placed && (bt_reg <= BT_W'(cnt_new)))
        begin
            bt_new = {bt_reg[BT_W-2:0], 1'b1};
        end

        res.found_value = '0;
        if (tok_ctl[CAPACITY].op == OP_FIND)
        begin
            if (tok_ctl[CAPACITY].hit)
            begin
                res.status      = ST_OK;
                res.found_value = VALUE_OUT_W'(tok_data[CAPACITY]);
            end
            else
            begin
                res.status = ST_MISS;
            end
        end
        else if (tok_ctl[CAPACITY].hit)
        begin
            res.status = ST_DUP;
        end
        else if (tok_ctl[CAPACITY].placed)
        begin
            res.status = ST_OK;
        end
        else
        begin
            res.status = ST_FULL;
        end
        res.entry_count  = COUNT_OUT_W'(cnt_new);
        res.bucket_count = COUNT_OUT_W'(bt_new);
    end

    always_comb
    begin
        busy_next       = busy_reg;
        count_next      = count_reg;
        bt_next         = bt_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end

        if (exit_tok)
        begin
            busy_next  = 1'b0;
            count_next = cnt_new;
            bt_next    = bt_new;
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                pend_next       = res;
                pend_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            bt_reg         <= BT_W'(1);
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            bt_reg         <= bt_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.found_value  = out_reg.found_value;
    assign rsp.entry_count  = out_reg.entry_count;
    assign rsp.bucket_count = out_reg.bucket_count;

    a_exit_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok |-> (busy_reg && !pend_valid_reg))
        else $error("token left chain with no request in flight");

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending response without output response");

    a_bucket_above_count: assert property (@(posedge clk) disable iff (!rst_n)
        BT_W'(count_reg) < bt_reg)
        else $error("bucket count not above entry count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok && tok_ctl[CAPACITY].placed |-> count_reg < CNT_W'(CAPACITY))
        else $error("insert placed into a full table");

endmodule
`default_nettype wire

>>> rtl/core/chm_cell.sv
// One storage cell of the hash map chain: holds one entry, checks and forwards the token.
`timescale 1ns / 1ps
`default_nettype none
module chm_cell #(
    parameter int VALUE_BITS = chm_pkg::VALUE_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  chm_pkg::tok_ctl_t            ctl_in,
    input  wire  [chm_pkg::KEY_W-1:0]    key_in,
    input  wire  [VALUE_BITS-1:0]        data_in,
    output chm_pkg::tok_ctl_t            ctl_out,
    output logic [chm_pkg::KEY_W-1:0]    key_out,
    output logic [VALUE_BITS-1:0]        data_out
);
    import chm_pkg::*;

    logic                  valid_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    tok_ctl_t              ctl_reg, ctl_next;
    logic [KEY_W-1:0]      key_out_reg;
    logic [VALUE_BITS-1:0] data_out_reg, data_next;

    logic match;
    logic wr;

    assign match = valid_reg && (key_reg == key_in);

    // Slots fill in order, so the first empty cell seen by an insert is the
    // next free slot; every possible duplicate lies upstream of it.
    always_comb
    begin
        ctl_next  = ctl_in;
        data_next = data_in;
        wr        = 1'b0;
        if (ctl_in.active)
        begin
            if (match && !ctl_in.hit)
            begin
                ctl_next.hit = 1'b1;
                if (ctl_in.op == OP_FIND)
                begin
                    data_next = value_reg;
                end
            end
            if (ctl_in.op == OP_INSERT && !ctl_in.hit && !ctl_in.placed && !valid_reg)
            begin
                wr              = 1'b1;
                ctl_next.placed = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (wr)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_out_reg  <= key_in;
        data_out_reg <= data_next;
        if (wr)
        begin
            key_reg   <= key_in;
            value_reg <= data_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign key_out  = key_out_reg;
    assign data_out = data_out_reg;

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> valid_reg)
        else $error("cell lost its entry");

    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr |=> (ctl_reg.placed && valid_reg))
        else $error("write not reflected in token");

    a_place_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.placed |-> (ctl_reg.op == OP_INSERT && !ctl_reg.hit))
        else $error("placed token is not a clean insert");

endmodule
`default_nettype wire

>>> test/chm_checker.sv
// Checker for the chained hash map: tracks the table and compares every response.
`timescale 1ns / 1ps
module chm_checker
    import chm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    chm_req_if   req,
    chm_rsp_if   rsp,
    output int   mismatch_count,
    output int   outstanding
);

    // Entries fill slots in order and are never removed, so slot i is live iff i < live_entries.
    logic [KEY_W-1:0]       slot_key   [CAPACITY];
    logic [VALUE_OUT_W-1:0] slot_value [CAPACITY];
    int                     live_entries;
    int                     buckets;
    rsp_t                   due_responses[$];

    // Applies one request to the table copy and returns the response it must produce.
    function automatic rsp_t lookup_or_store(op_t op, logic [KEY_W-1:0] key,
                                             logic [VALUE_OUT_W-1:0] value);
        rsp_t r;
        int   slot;
        r    = '0;
        slot = -1;
        for (int i = 0; i < live_entries; i++)
        begin
            if (slot_key[i] == key)
                slot = i;
        end
        if (op == OP_FIND)
        begin
            if (slot >= 0)
            begin
                r.status      = ST_OK;
                r.found_value = slot_value[slot];
            end
            else
                r.status = ST_MISS;
        end
        else if (slot >= 0)
            r.status = ST_DUP;
        else if (live_entries >= CAPACITY)
            r.status = ST_FULL;
        else
        begin
            slot_key[live_entries]   = key;
            slot_value[live_entries] = value;
            live_entries++;
            if (buckets <= live_entries)
                buckets = 2 * buckets + 1;
            r.status = ST_OK;
        end
        r.entry_count  = COUNT_OUT_W'(live_entries);
        r.bucket_count = COUNT_OUT_W'(buckets);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            live_entries = 0;
            buckets      = 1;
            due_responses.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: response with no request pending: status %0d value %h",
                                 $realtime, rsp.status, rsp.found_value);
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (rsp.status !== want.status || rsp.found_value !== want.found_value ||
                        rsp.entry_count !== want.entry_count ||
                        rsp.bucket_count !== want.bucket_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: mismatch (expected/actual): status %0d/%0d value %h/%h",
                                     $realtime, want.status, rsp.status,
                                     want.found_value, rsp.found_value);
                            $display("    entries %0d/%0d buckets %0d/%0d",
                                     want.entry_count, rsp.entry_count,
                                     want.bucket_count, rsp.bucket_count);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
                due_responses.insert(due_responses.size(),
                                     lookup_or_store(req.op, req.key,
                                                     VALUE_OUT_W'(req.value)));
            outstanding = due_responses.size();
        end
    end

endmodule

>>> test/tb_chained_hash_map.sv
// Testbench top for the chained hash map: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_chained_hash_map;
    import chm_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int RANDOM_OPS = 700;
    // Allow for the longest sender gap, a full drain and receiver stalls, several times over.
    localparam int STALL_LIMIT = 20 * (CAPACITY + 1);

    logic clk;
    logic rst_n;
    logic calm;         // no idling on either side while set
    int   mismatches;
    int   pending;
    int   quiet_cycles;

    logic [KEY_W-1:0] used_keys[$];   // every key ever offered in an insert

    chm_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
    chm_rsp_if                            rsp_ch ();

    chained_hash_map #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    chm_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatches),
        .outstanding    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Response side: random stalls, ~6 in 100, none during the calm stretch.
    always @(posedge clk)
    begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    // Watchdog: any accept on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic bit is_used(logic [KEY_W-1:0] key);
        foreach (used_keys[i])
        begin
            if (used_keys[i] == key)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Presents one request and returns at the edge that accepts it; valid stays high.
    task automatic push_request(op_t op, logic [KEY_W-1:0] key, logic [VALUE_BITS-1:0] value);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        req_ch.value <= value;
        if (op == OP_INSERT && !is_used(key))
            used_keys.insert(used_keys.size(), key);
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drops valid for a while; the payload carries junk the block must ignore.
    task automatic idle_sender(int cycles);
        req_ch.valid <= 1'b0;
        req_ch.op    <= op_t'($urandom_range(0, 1));
        req_ch.key   <= KEY_W'($urandom);
        req_ch.value <= VALUE_BITS'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the sender off until every response is back; pending is read
    // at the falling edge so the checker's update at the rising edge is settled.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        op_t                   op;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
        int                    sel;

        rst_n        <= 1'b0;
        calm         <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_FIND;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table miss, growth steps 1->3->7->15, duplicates,
        // key and value extremes, find ignoring its value field.
        push_request(OP_FIND,   '0, '0);
        push_request(OP_INSERT, '0, '0);
        push_request(OP_INSERT, '0, '1);                 // duplicate
        push_request(OP_FIND,   '0, '1);                 // hit, value field ignored
        push_request(OP_INSERT, '1, '1);                 // max key, all-ones value
        push_request(OP_FIND,   '1, '0);
        push_request(OP_FIND,   KEY_W'(1), '1);          // miss
        push_request(OP_INSERT, KEY_W'(1), 32'h5a5a_a5a5);
        push_request(OP_INSERT, KEY_W'(8), 32'ha5a5_5a5a); // shares bucket with 1 (mod 7)
        push_request(OP_INSERT, KEY_W'(15), 32'h0000_0001);
        push_request(OP_INSERT, 31'h5555_5555, 32'h8000_0000);
        push_request(OP_INSERT, 31'h2aaa_aaaa, 32'h7fff_ffff); // grows to 15
        push_request(OP_FIND,   KEY_W'(8), '0);
        push_request(OP_FIND,   KEY_W'(22), '0);        // absent
        push_request(OP_INSERT, '1, '0);                 // duplicate of max key
        push_request(OP_FIND,   31'h2aaa_aaaa, '0);
        drain_responses();

        // Random traffic: mostly keys already offered or small colliding keys,
        // so finds hit, inserts hit duplicates, and the table fills to capacity.
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            calm <= (n >= 250 && n < 400);
            sel = $urandom_range(0, 99);
            if (sel < 45 && used_keys.size() > 0)
                key = used_keys[$urandom_range(0, used_keys.size() - 1)];
            else if (sel < 75)
                key = KEY_W'($urandom_range(0, 300));
            else if (sel < 80)
                key = '1 - KEY_W'($urandom_range(0, 3));
            else
                key = KEY_W'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 10)
                value = '0;
            else if (sel < 20)
                value = '1;
            else
                value = VALUE_BITS'($urandom);
            op = ($urandom_range(0, 99) < 25) ? OP_INSERT : OP_FIND;
            push_request(op, key, value);
            if (n == 500)
                drain_responses();
            else if (!(n >= 250 && n < 400) && $urandom_range(0, 99) < 6)
                idle_sender($urandom_range(1, CAPACITY + 4));
        end

        // Make sure the full table is exercised: fresh keys past capacity,
        // then a duplicate, one more insert and a hit against the full table.
        while (used_keys.size() <= CAPACITY)
        begin
            key = KEY_W'($urandom);
            if (!is_used(key))
                push_request(OP_INSERT, key, VALUE_BITS'($urandom));
        end
        push_request(OP_INSERT, used_keys[0], VALUE_BITS'($urandom));
        push_request(OP_INSERT, KEY_W'($urandom) | 31'h4000_0000, '1);
        push_request(OP_FIND, used_keys[$urandom_range(0, CAPACITY - 1)], '0);

        drain_responses();
        repeat (CAPACITY + 4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/chm_pkg.sv
rtl/core/chm_intf.sv
rtl/core/chm_cell.sv
rtl/core/chained_hash_map.sv
test/chm_checker.sv
test/tb_chained_hash_map.sv
